### design/bcc_pkg.sv
// Package: payload types, register indexes and constants for the button click classifier.
`timescale 1ns / 1ps

package bcc_pkg;

    localparam int KEY_W   = 2;
    localparam int TIME_W  = 13;
    localparam int CLICK_W = 8;
    localparam int KIND_W  = 2;
    localparam int CFG_W   = 3;

    typedef struct packed {
        logic [KEY_W-1:0] key_index;
        logic             key_level;
    } in_item_t;

    typedef struct packed {
        logic [KEY_W-1:0]  event_key;
        logic [KIND_W-1:0] event_kind;
    } out_item_t;

    localparam logic [KIND_W-1:0] KIND_PRESSED = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LONG    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SINGLE  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_DOUBLE  = 2'd3;

    localparam logic [CFG_W-1:0] REG_PRESS_TIME      = 3'd0;
    localparam logic [CFG_W-1:0] REG_LONG_PRESS_TIME = 3'd1;
    localparam logic [CFG_W-1:0] REG_CLICK_MIN_HOLD  = 3'd2;
    localparam logic [CFG_W-1:0] REG_CLICK_MAX_HOLD  = 3'd3;
    localparam logic [CFG_W-1:0] REG_RELEASE_TIMEOUT = 3'd4;
    localparam logic [CFG_W-1:0] REG_HOLD_CEILING    = 3'd5;

    localparam logic [TIME_W-1:0] RST_PRESS_TIME      = 13'd1;
    localparam logic [TIME_W-1:0] RST_LONG_PRESS_TIME = 13'd100;
    localparam logic [TIME_W-1:0] RST_CLICK_MIN_HOLD  = 13'd2;
    localparam logic [TIME_W-1:0] RST_CLICK_MAX_HOLD  = 13'd30;
    localparam logic [TIME_W-1:0] RST_RELEASE_TIMEOUT = 13'd10;
    localparam logic [TIME_W-1:0] RST_HOLD_CEILING    = 13'd8000;

    localparam logic [TIME_W-1:0]  HOLD_RESET  = 13'd100;
    localparam logic [CLICK_W-1:0] CLICK_SAT   = 8'd255;
    localparam logic [CLICK_W-1:0] DOUBLE_LOW  = 8'd3;
    localparam logic [CLICK_W-1:0] CLICK_LIMIT = 8'd5;

endpackage

### design/button_click_classifier.sv
// Top level: per-key multi-click and long-press classifier.
//
// Usage:
//   in channel (in_valid/in_ready/in_data) carries one scan tick: key index and
//   active-low pin level. out channel (out_valid/out_ready/out_data) carries an
//   event: key and kind (pressed, long press, single click, double click).
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes one of six
//   13-bit timing registers; cfg_ready is always high, unknown indexes drop.
//   A tick is registered at transfer, then classified against the per-key
//   state once the output register is free; the event, if any, lands in the
//   output register. Throughput is one tick per cycle while the output is not
//   stalled, set by the single read-modify-write of the per-key state
//   registers. A tick may cause no event.
//   Ticks for a key at or above NUM_KEYS are dropped without effect.
//   Reset clears the pipeline, loads the register defaults and sets every key
//   released with hold 100 and no clicks.
//   When out_ready is low with an event waiting, one more tick is held in the
//   input register; then in_ready drops until the event transfers.
`timescale 1ns / 1ps

module button_click_classifier
    import bcc_pkg::*;
#(
    parameter int NUM_KEYS = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  in_item_t            in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output out_item_t           out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CFG_W-1:0]    cfg_index,
    input  logic [TIME_W-1:0]   cfg_data
);

    localparam int CMP_W = 5;

    logic [TIME_W-1:0] press_time_reg;
    logic [TIME_W-1:0] long_press_time_reg;
    logic [TIME_W-1:0] click_min_hold_reg;
    logic [TIME_W-1:0] click_max_hold_reg;
    logic [TIME_W-1:0] release_timeout_reg;
    logic [TIME_W-1:0] hold_ceiling_reg;

    logic              last_level_reg [NUM_KEYS];
    logic [TIME_W-1:0] hold_reg       [NUM_KEYS];
    logic [CLICK_W-1:0] click_reg     [NUM_KEYS];

    logic     s1_valid_reg;
    in_item_t s1_item_reg;

    logic      out_valid_reg;
    out_item_t out_item_reg;

    logic s2_free;
    logic process;
    logic key_hit;

    logic               cur_level;
    logic [TIME_W-1:0]  cur_hold;
    logic [CLICK_W-1:0] cur_click;

    logic [TIME_W-1:0]  hold_next;
    logic [CLICK_W-1:0] click_next;
    logic [TIME_W-1:0]  hold_edge;
    logic [CLICK_W-1:0] click_edge;
    logic               fire;
    logic [KIND_W-1:0]  kind;

    assign cfg_ready = 1'b1;
    assign s2_free   = !out_valid_reg || out_ready;
    assign in_ready  = !s1_valid_reg || s2_free;
    assign process   = s1_valid_reg && s2_free;
    assign key_hit   = CMP_W'(s1_item_reg.key_index) < CMP_W'(NUM_KEYS);

    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            press_time_reg      <= RST_PRESS_TIME;
            long_press_time_reg <= RST_LONG_PRESS_TIME;
            click_min_hold_reg  <= RST_CLICK_MIN_HOLD;
            click_max_hold_reg  <= RST_CLICK_MAX_HOLD;
            release_timeout_reg <= RST_RELEASE_TIMEOUT;
            hold_ceiling_reg    <= RST_HOLD_CEILING;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_PRESS_TIME:      press_time_reg      <= cfg_data;
                REG_LONG_PRESS_TIME: long_press_time_reg <= cfg_data;
                REG_CLICK_MIN_HOLD:  click_min_hold_reg  <= cfg_data;
                REG_CLICK_MAX_HOLD:  click_max_hold_reg  <= cfg_data;
                REG_RELEASE_TIMEOUT: release_timeout_reg <= cfg_data;
                REG_HOLD_CEILING:    hold_ceiling_reg    <= cfg_data;
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_item_reg <= in_data;
        end
    end

    always_comb
    begin
        cur_level = 1'b1;
        cur_hold  = HOLD_RESET;
        cur_click = '0;
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            if (CMP_W'(k) == CMP_W'(s1_item_reg.key_index))
            begin
                cur_level = last_level_reg[k];
                cur_hold  = hold_reg[k];
                cur_click = click_reg[k];
            end
        end
    end

    always_comb
    begin
        hold_edge  = cur_hold;
        click_edge = cur_click;
        if (s1_item_reg.key_level != cur_level)
        begin
            if (cur_hold >= click_min_hold_reg && cur_hold < click_max_hold_reg)
            begin
                if (cur_click != CLICK_SAT)
                begin
                    click_edge = cur_click + 8'd1;
                end
            end
            else if (cur_hold >= click_max_hold_reg)
            begin
                click_edge = '0;
            end
            hold_edge = '0;
        end

        hold_next = hold_edge;
        if (hold_edge < hold_ceiling_reg)
        begin
            hold_next = hold_edge + 13'd1;
        end

        click_next = click_edge;
        fire       = 1'b0;
        kind       = KIND_PRESSED;
        if (!s1_item_reg.key_level)
        begin
            if (hold_next == long_press_time_reg)
            begin
                fire = 1'b1;
                kind = KIND_LONG;
            end
            else if (hold_next == press_time_reg)
            begin
                fire = 1'b1;
                kind = KIND_PRESSED;
            end
        end
        else if (hold_next == release_timeout_reg)
        begin
            if (click_edge != '0 && click_edge < DOUBLE_LOW)
            begin
                fire = 1'b1;
                kind = KIND_SINGLE;
            end
            else if (click_edge >= DOUBLE_LOW && click_edge < CLICK_LIMIT)
            begin
                fire = 1'b1;
                kind = KIND_DOUBLE;
            end
            click_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_KEYS; k++)
            begin
                last_level_reg[k] <= 1'b1;
                hold_reg[k]       <= HOLD_RESET;
                click_reg[k]      <= '0;
            end
        end
        else if (process && key_hit)
        begin
            for (int k = 0; k < NUM_KEYS; k++)
            begin
                if (CMP_W'(k) == CMP_W'(s1_item_reg.key_index))
                begin
                    last_level_reg[k] <= s1_item_reg.key_level;
                    hold_reg[k]       <= hold_next;
                    click_reg[k]      <= click_next;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s2_free)
        begin
            out_valid_reg <= process && key_hit && fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (process && key_hit && fire)
        begin
            out_item_reg.event_key  <= s1_item_reg.key_index;
            out_item_reg.event_kind <= kind;
        end
    end

`ifndef NO_ASSERTIONS
    a_key_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> CMP_W'(out_item_reg.event_key) < CMP_W'(NUM_KEYS))
        else $error("event for a key beyond NUM_KEYS");

    a_event_from_tick: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_valid_reg))
        else $error("event without a registered tick");

    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !in_ready) |=> (s1_valid_reg && $stable(s1_item_reg)))
        else $error("input register lost a stalled tick");
`endif

endmodule

### verif/button_click_classifier_tb.sv
// Testbench: random and directed scan ticks checked against a per-key click predictor.
`timescale 1ns / 1ps

module button_click_classifier_tb;
    import bcc_pkg::*;

    localparam int KEYS           = 4;
    localparam int SETTLE_CYCLES  = 4;
    localparam int HOLDOFF_CYCLES = 80;
    localparam int SAT_EDGES      = 258;

    localparam logic [CFG_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_W-1:0] REG_SPARE_7 = 3'd7;

    class click_scoreboard;
        logic [TIME_W-1:0]             press_time;
        logic [TIME_W-1:0]             long_time;
        logic [TIME_W-1:0]             min_hold;
        logic [TIME_W-1:0]             max_hold;
        logic [TIME_W-1:0]             rel_timeout;
        logic [TIME_W-1:0]             ceiling;
        logic [KEYS-1:0]               level_q;
        logic [KEYS-1:0][TIME_W-1:0]   hold_q;
        logic [KEYS-1:0][CLICK_W-1:0]  clicks_q;
        out_item_t                     events_due [$];
        int                            errors;

        function new();
            press_time  = RST_PRESS_TIME;
            long_time   = RST_LONG_PRESS_TIME;
            min_hold    = RST_CLICK_MIN_HOLD;
            max_hold    = RST_CLICK_MAX_HOLD;
            rel_timeout = RST_RELEASE_TIMEOUT;
            ceiling     = RST_HOLD_CEILING;
            level_q     = '1;
            for (int k = 0; k < KEYS; k++)
            begin
                hold_q[k]   = HOLD_RESET;
                clicks_q[k] = '0;
            end
            errors = 0;
        endfunction

        function void set_reg(logic [CFG_W-1:0] idx, logic [TIME_W-1:0] val);
            case (idx)
                REG_PRESS_TIME:      press_time  = val;
                REG_LONG_PRESS_TIME: long_time   = val;
                REG_CLICK_MIN_HOLD:  min_hold    = val;
                REG_CLICK_MAX_HOLD:  max_hold    = val;
                REG_RELEASE_TIMEOUT: rel_timeout = val;
                REG_HOLD_CEILING:    ceiling     = val;
                default:             ;
            endcase
        endfunction

        function void note_tick(in_item_t t);
            int                k;
            logic [TIME_W-1:0] h;
            logic              fire;
            logic [KIND_W-1:0] kind;
            out_item_t         ev;
            k    = int'(t.key_index);
            fire = 1'b0;
            kind = KIND_PRESSED;
            if (k >= KEYS)
                return;
            if (t.key_level != level_q[k])
            begin
                h = hold_q[k];
                if (h >= min_hold && h < max_hold)
                begin
                    if (clicks_q[k] != CLICK_SAT)
                        clicks_q[k] = clicks_q[k] + 1'b1;
                end
                else if (h >= max_hold)
                begin
                    clicks_q[k] = '0;
                end
                hold_q[k]  = '0;
                level_q[k] = t.key_level;
            end
            if (hold_q[k] < ceiling)
                hold_q[k] = hold_q[k] + 1'b1;
            h = hold_q[k];
            if (t.key_level == 1'b0)
            begin
                if (h == press_time)
                begin
                    fire = 1'b1;
                    kind = KIND_PRESSED;
                end
                if (h == long_time)
                begin
                    fire = 1'b1;
                    kind = KIND_LONG;
                end
            end
            else if (h == rel_timeout)
            begin
                if (clicks_q[k] >= 1 && clicks_q[k] < DOUBLE_LOW)
                begin
                    fire = 1'b1;
                    kind = KIND_SINGLE;
                end
                else if (clicks_q[k] >= DOUBLE_LOW && clicks_q[k] < CLICK_LIMIT)
                begin
                    fire = 1'b1;
                    kind = KIND_DOUBLE;
                end
                clicks_q[k] = '0;
            end
            if (fire)
            begin
                ev.event_key  = k[KEY_W-1:0];
                ev.event_kind = kind;
                events_due.push_back(ev);
            end
        endfunction

        function void check_event(out_item_t got);
            out_item_t want;
            if (events_due.size() == 0)
            begin
                errors++;
                $display("%0t: event expected none actual key %0d kind %0d",
                         $time, got.event_key, got.event_kind);
                return;
            end
            want = events_due.pop_front();
            if (got.event_key !== want.event_key)
            begin
                errors++;
                $display("%0t: event_key expected %0d actual %0d",
                         $time, want.event_key, got.event_key);
            end
            if (got.event_kind !== want.event_kind)
            begin
                errors++;
                $display("%0t: event_kind expected %0d actual %0d",
                         $time, want.event_kind, got.event_kind);
            end
        endfunction

        function int pending();
            return events_due.size();
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    in_item_t          in_data;
    logic              out_valid;
    logic              out_ready;
    out_item_t         out_data;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [CFG_W-1:0]  cfg_index;
    logic [TIME_W-1:0] cfg_data;

    click_scoreboard   sb;
    int                tx_idle_pct;
    int                rx_idle_pct;
    bit                holdoff_req;
    logic [KEYS-1:0]   want_level;
    int                run_left [KEYS];
    int                cur_key;

    button_click_classifier #(
        .NUM_KEYS (KEYS)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("button_click_classifier: mismatch");
        $finish;
    end

    initial
    begin
        int stall;
        out_ready = 1'b0;
        stall     = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                sb.check_event(out_data);
            if (holdoff_req && stall == 0)
            begin
                stall       = HOLDOFF_CYCLES;
                holdoff_req = 1'b0;
            end
            if (stall > 0)
            begin
                stall--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    task automatic send_tick(input in_item_t t);
        in_valid <= 1'b1;
        in_data  <= t;
        do @(posedge clk); while (!in_ready);
        sb.note_tick(t);
        if ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < tx_idle_pct);
        end
    endtask

    task automatic send_run(input int k, input logic lvl, input int n);
        in_item_t t;
        t.key_index = k[KEY_W-1:0];
        t.key_level = lvl;
        repeat (n) send_tick(t);
    endtask

    function automatic int draw_run();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return $urandom_range(1, 6);
        if (r < 90)
            return $urandom_range(1, 16);
        return $urandom_range(1, 110);
    endfunction

    // Mostly well-formed press/release runs per key, with some random levels mixed in.
    task automatic send_random(input int count);
        in_item_t t;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 99) >= 70)
                cur_key = $urandom_range(0, KEYS - 1);
            t.key_index = cur_key[KEY_W-1:0];
            if ($urandom_range(0, 99) < 10)
            begin
                t.key_level = 1'($urandom_range(0, 1));
            end
            else
            begin
                if (run_left[cur_key] == 0)
                begin
                    want_level[cur_key] = ~want_level[cur_key];
                    run_left[cur_key]   = draw_run();
                end
                run_left[cur_key]--;
                t.key_level = want_level[cur_key];
            end
            send_tick(t);
        end
    endtask

    // Toggle one key on each of its ticks, with ticks for other keys mixed in, until the click count passes saturation.
    task automatic send_click_burst();
        in_item_t t;
        int       s;
        s = $urandom_range(0, KEYS - 1);
        send_run(s, 1'b1, 6);
        for (int i = 0; i < SAT_EDGES; i++)
        begin
            if ($urandom_range(0, 99) < 15)
            begin
                t.key_index = KEY_W'((s + $urandom_range(1, KEYS - 1)) % KEYS);
                t.key_level = 1'($urandom_range(0, 1));
                send_tick(t);
            end
            t.key_index = s[KEY_W-1:0];
            t.key_level = i[0];
            send_tick(t);
        end
        send_run(s, 1'b1, 6);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_W-1:0] idx, input logic [TIME_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        sb.set_reg(idx, val);
    endtask

    task automatic write_regs(input logic [TIME_W-1:0] pt, input logic [TIME_W-1:0] lp,
                              input logic [TIME_W-1:0] mn, input logic [TIME_W-1:0] mx,
                              input logic [TIME_W-1:0] rt, input logic [TIME_W-1:0] hc);
        cfg_write(REG_PRESS_TIME, pt);
        cfg_write(REG_LONG_PRESS_TIME, lp);
        cfg_write(REG_CLICK_MIN_HOLD, mn);
        cfg_write(REG_CLICK_MAX_HOLD, mx);
        cfg_write(REG_RELEASE_TIMEOUT, rt);
        cfg_write(REG_HOLD_CEILING, hc);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        sb          = new();
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        tx_idle_pct = 24;
        rx_idle_pct = 54;
        holdoff_req = 1'b0;
        cur_key     = 0;
        want_level  = '1;
        for (int k = 0; k < KEYS; k++)
            run_left[k] = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // press then single click on key 0, double click on key 3
        send_run(0, 1'b0, 2);
        send_run(0, 1'b1, 10);
        send_run(3, 1'b0, 2);
        send_run(3, 1'b1, 2);
        send_run(3, 1'b0, 2);
        send_run(3, 1'b1, 10);
        send_random(100);
        drain();

        // press and long press on the same hold; hold off the output to back up the input
        write_regs(2, 2, 1, 6, 4, 50);
        send_random(20);
        holdoff_req = 1'b1;
        send_random(130);
        drain();

        cfg_write(REG_SPARE_6, '1);
        cfg_write(REG_SPARE_7, 13'h0AAA);
        write_regs('1, '1, '1, '1, '1, '1);
        send_random(60);
        drain();

        tx_idle_pct = 54;
        rx_idle_pct = 24;
        write_regs(0, 0, 0, 0, 0, 0);
        send_random(100);
        drain();

        // inverted click window
        write_regs(1, 9, 8, 3, 6, 20);
        send_random(150);
        drain();

        // ceiling below the holds left over
        write_regs(2, 3, 1, 3, 3, 3);
        send_random(100);
        drain();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_regs(3, 4, 1, '1, 5, '1);
        send_click_burst();
        drain();

        for (int p = 0; p < 3; p++)
        begin
            write_regs(TIME_W'($urandom_range(0, 12)), TIME_W'($urandom_range(0, 40)),
                       TIME_W'($urandom_range(0, 4)), TIME_W'($urandom_range(2, 12)),
                       TIME_W'($urandom_range(0, 12)), TIME_W'($urandom_range(1, 60)));
            send_random(50);
            drain();
            send_random(50);
            drain();
        end

        if (sb.errors == 0 && sb.pending() == 0)
            $display("button_click_classifier: match");
        else
            $display("button_click_classifier: mismatch");
        $finish;
    end

endmodule
